>>> src/usil_pkg.sv
package usil_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  localparam logic [1:0] REG_RANGE_MIN = 2'd0;
  localparam logic [1:0] REG_RANGE_MAX = 2'd1;
  localparam logic [1:0] REG_STEP_SHIFT = 2'd2;

  typedef struct packed {
    logic signed [15:0] range_min;
    logic signed [15:0] range_max;
    logic [3:0]         step_shift;
  } usil_cfg_t;

  // one classified beat, as it travels from the front end to the back end
  typedef struct packed {
    logic               is_conv;
    logic               wr_ok;
    logic [ADDR_W-1:0]  wr_addr;
    logic [15:0]        wr_data;
    logic               a0_ok;
    logic [ADDR_W-1:0]  a0;
    logic               a1_ok;
    logic [ADDR_W-1:0]  a1;
    logic signed [16:0] delta;
  } usil_item_t;

endpackage

>>> src/uniform_step_interp_lut.sv
// Piecewise linear lookup over a table of signed 16-bit breakpoints spaced
// 2^step_shift apart from range_min. One beat is taken per clock whenever
// busy is low; busy only rises if the internal two-entry queue fills, which
// does not happen because the back end drains a beat every cycle. A convert
// beat gives its result on converted with done high for one cycle, after
// passing the queue, registered dual-port table read, entry difference,
// 17x17 multiply and round/shift/add. Write beats give no result. Table
// words hold garbage until written; there is no clear pass.
// Configuration writes belong to idle periods only.
module uniform_step_interp_lut (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [7:0]         entry_index,
  input  logic signed [15:0] entry_value,
  input  logic signed [15:0] sample,
  output logic               done,
  output logic signed [15:0] converted,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import usil_pkg::*;

  usil_cfg_t  cfg;
  usil_item_t front_item;
  usil_item_t head_item;
  logic       push;
  logic       head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_min  <= 16'sd0;
      cfg.range_max  <= 16'sd32767;
      cfg.step_shift <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_MIN:  cfg.range_min  <= cfg_data;
        REG_RANGE_MAX:  cfg.range_max  <= cfg_data;
        REG_STEP_SHIFT: cfg.step_shift <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign push = start && !busy;

  usil_front u_front (
    .cfg         (cfg),
    .req_type    (req_type),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .sample      (sample),
    .item        (front_item)
  );

  usil_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (busy),
    .pop_valid (head_valid),
    .pop_item  (head_item)
  );

  usil_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (head_valid),
    .item       (head_item),
    .step_shift (cfg.step_shift),
    .done       (done),
    .converted  (converted)
  );

  a_convert_latency: assert property (@(posedge clk) disable iff (rst)
    push && req_type == REQ_CONVERT |-> ##5 done)
    else $error("convert beat did not complete in five cycles");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(push && req_type == REQ_CONVERT, 5))
    else $error("result strobe without a matching convert beat");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    push && req_type == REQ_WRITE |-> ##5 !done)
    else $error("write beat produced a result");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("queue filled although the back end drains every cycle");

endmodule

>>> src/usil_front.sv
module usil_front (
  input  usil_pkg::usil_cfg_t  cfg,
  input  logic                 req_type,
  input  logic [7:0]           entry_index,
  input  logic signed [15:0]   entry_value,
  input  logic signed [15:0]   sample,
  output usil_pkg::usil_item_t item
);
  import usil_pkg::*;

  logic               below;
  logic               above;
  logic               hi_ge_lo;
  logic [15:0]        span;
  logic [15:0]        top;
  logic               top_ok;
  logic [ADDR_W-1:0]  top_addr;
  logic [15:0]        offs;
  logic [7:0]         seg;
  logic [8:0]         seg1;
  logic signed [15:0] pos;
  logic signed [16:0] dist_raw;

  assign below    = sample < cfg.range_min;
  assign above    = sample >= cfg.range_max;
  assign hi_ge_lo = cfg.range_max >= cfg.range_min;

  // reversed range clamps high to entry 0
  assign span     = cfg.range_max - cfg.range_min;
  assign top      = span >> cfg.step_shift;
  assign top_ok   = !hi_ge_lo || ({1'b0, top} < 17'(TABLE_DEPTH));
  assign top_addr = hi_ge_lo ? top[ADDR_W-1:0] : '0;

  assign offs     = sample - cfg.range_min;
  assign seg      = 8'(offs >> cfg.step_shift);
  assign seg1     = 9'(seg) + 9'd1;
  assign pos      = (16'(seg) << cfg.step_shift) + cfg.range_min;
  assign dist_raw = 17'(sample) - 17'(pos);

  always_comb begin
    item.is_conv = (req_type == REQ_CONVERT);
    item.wr_ok   = 9'(entry_index) < 9'(TABLE_DEPTH);
    item.wr_addr = entry_index[ADDR_W-1:0];
    item.wr_data = entry_value;
    item.a1_ok   = seg1 < 9'(TABLE_DEPTH);
    item.a1      = seg1[ADDR_W-1:0];
    // clamped beats carry zero distance and a zero upper word, so the back
    // end returns t0 as is and never depends on the neighbor entry
    if (below) begin
      item.a0_ok = 1'b1;
      item.a0    = '0;
      item.a1_ok = 1'b0;
      item.delta = '0;
    end else if (above) begin
      item.a0_ok = top_ok;
      item.a0    = top_addr;
      item.a1_ok = 1'b0;
      item.delta = '0;
    end else begin
      item.a0_ok = 9'(seg) < 9'(TABLE_DEPTH);
      item.a0    = seg[ADDR_W-1:0];
      item.delta = dist_raw;
    end
  end

endmodule

>>> src/usil_queue.sv
module usil_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  usil_pkg::usil_item_t push_item,
  output logic                 full,
  output logic                 pop_valid,
  output usil_pkg::usil_item_t pop_item
);
  import usil_pkg::*;

  usil_item_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              pop;

  assign full      = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop       = pop_valid;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/usil_back.sv
module usil_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  usil_pkg::usil_item_t item,
  input  logic [3:0]           step_shift,
  output logic                 done,
  output logic signed [15:0]   converted
);
  import usil_pkg::*;

  logic [15:0] mem [TABLE_DEPTH];

  logic               v1;
  logic               ok0_1;
  logic               ok1_1;
  logic [15:0]        rd0;
  logic [15:0]        rd1;
  logic signed [16:0] dist1;

  logic               v2;
  logic signed [15:0] t0_2;
  logic signed [16:0] diff2;
  logic signed [16:0] dist2;

  logic               v3;
  logic signed [15:0] t0_3;
  logic signed [33:0] prod3;

  logic signed [15:0] t0;
  logic signed [15:0] t1;
  logic [15:0]        half;
  logic signed [34:0] acc;
  logic signed [34:0] acc_sh;

  // table write and both reads sit at the same stage, so a write is seen
  // by any convert beat behind it
  always_ff @(posedge clk) begin
    if (in_valid && !item.is_conv && item.wr_ok) begin
      mem[item.wr_addr] <= item.wr_data;
    end
    rd0 <= mem[item.a0];
    rd1 <= mem[item.a1];
  end

  assign t0 = ok0_1 ? rd0 : '0;
  assign t1 = ok1_1 ? rd1 : '0;

  assign half   = (16'd1 << step_shift) >> 1;
  assign acc    = 35'(prod3) + $signed({19'd0, half});
  assign acc_sh = acc >>> step_shift;

  always_ff @(posedge clk) begin
    ok0_1     <= item.a0_ok;
    ok1_1     <= item.a1_ok;
    dist1     <= item.delta;
    t0_2      <= t0;
    diff2     <= 17'(t1) - 17'(t0);
    dist2     <= dist1;
    t0_3      <= t0_2;
    prod3     <= diff2 * dist2;
    converted <= t0_3 + acc_sh[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid && item.is_conv;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

endmodule

>>> bench/uniform_step_interp_lut_tb.sv
`timescale 1ns / 100ps

module uniform_step_interp_lut_tb;
  import usil_pkg::*;

  localparam int DRAIN_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_CFG = 135;
  localparam logic signed [15:0] WORD_MIN = 16'sh8000;
  localparam logic signed [15:0] WORD_MAX = 16'sh7FFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic req_type = REQ_WRITE;
  logic [7:0] entry_index = '0;
  logic signed [15:0] entry_value = '0;
  logic signed [15:0] sample = '0;
  logic done;
  logic signed [15:0] converted;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_RANGE_MIN;
  logic [15:0] cfg_data = '0;

  // predictor state
  logic signed [15:0] lut_words [TABLE_DEPTH];
  logic signed [15:0] span_lo = 16'sd0;
  logic signed [15:0] span_hi = WORD_MAX;
  logic [3:0] span_shift = 4'd8;
  logic signed [15:0] pending_converted [$];

  int errors = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  uniform_step_interp_lut u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .sample(sample),
    .done(done),
    .converted(converted),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [15:0] entry_at(input int pos);
    if (pos >= TABLE_DEPTH) return '0;
    return lut_words[pos];
  endfunction

  function automatic logic signed [15:0] interp_result(input logic signed [15:0] v);
    int lo;
    int hi;
    int s;
    int top;
    int idx;
    logic signed [15:0] knot;
    longint t0;
    longint t1;
    longint delta;
    longint acc;
    longint res;
    lo = span_lo;
    hi = span_hi;
    s = span_shift;
    if (v < lo) return entry_at(0);
    if (v >= hi) begin
      top = (hi >= lo) ? ((hi - lo) >> s) : 0;
      return entry_at(top);
    end
    // segment index keeps 8 bits; its breakpoint wraps to 16 bits
    idx = ((v - lo) >> s) & 255;
    knot = 16'((idx << s) + lo);
    t0 = entry_at(idx);
    t1 = entry_at(idx + 1);
    delta = v - knot;
    acc = (t1 - t0) * delta + ((s == 0) ? 0 : (longint'(1) << (s - 1)));
    res = t0 + (acc >>> s);
    return res[15:0];
  endfunction

  function automatic logic signed [15:0] pick_sample();
    int v;
    int r;
    int lo_i;
    int hi_i;
    logic [15:0] raw;
    raw = 16'($urandom);
    v = $signed(raw);
    r = $urandom_range(99);
    lo_i = (span_lo < span_hi) ? span_lo : span_hi;
    hi_i = (span_lo < span_hi) ? span_hi : span_lo;
    if (r >= 40 && r < 70) begin
      v = lo_i - 4 + $urandom_range(0, hi_i - lo_i + 8);
    end else if (r >= 70 && r < 85) begin
      v = int'(span_lo) + int'($urandom_range(0, 300) << span_shift)
          + int'($urandom_range(0, 2)) - 1;
    end else if (r >= 85) begin
      case ($urandom_range(5))
        0: v = WORD_MIN;
        1: v = WORD_MAX;
        2: v = span_lo;
        3: v = span_hi;
        4: v = span_lo - 1;
        default: v = span_hi - 1;
      endcase
    end
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] pick_word();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? WORD_MAX : WORD_MIN;
    return 16'($urandom);
  endfunction

  task automatic send_beat(input logic rt, input logic [7:0] idx,
                           input logic signed [15:0] val, input logic signed [15:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rt;
    entry_index <= idx;
    entry_value <= val;
    sample <= smp;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (rt == REQ_CONVERT) pending_converted.push_back(interp_result(smp));
    else lut_words[idx] = val;
  endtask

  task automatic write_entry(input logic [7:0] idx, input logic signed [15:0] val);
    send_beat(REQ_WRITE, idx, val, 16'($urandom));
  endtask

  task automatic convert_sample(input logic signed [15:0] smp);
    send_beat(REQ_CONVERT, 8'($urandom), 16'($urandom), smp);
  endtask

  task automatic wait_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_converted.size() != 0);
  endtask

  // write beats leave no trace in the queue, so give the pipe time to empty
  task automatic wait_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic signed [15:0] lo, input logic signed [15:0] hi,
                             input logic [3:0] sh);
    cfg_we <= 1'b1;
    cfg_index <= REG_RANGE_MIN;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_RANGE_MAX;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= REG_STEP_SHIFT;
    cfg_data <= {12'd0, sh};
    @(posedge clk);
    cfg_we <= 1'b0;
    span_lo = lo;
    span_hi = hi;
    span_shift = sh;
  endtask

  // only entries 0, 1, 2 and 255 are written before the full table load
  task automatic test_table_edges();
    write_entry(8'd0, WORD_MIN);
    write_entry(8'd1, WORD_MAX);
    write_entry(8'd2, WORD_MIN);
    write_entry(8'd255, WORD_MAX);
    wait_idle();
    load_config(WORD_MIN, WORD_MAX, 4'd15);
    convert_sample(WORD_MIN);
    convert_sample(-16'sd1);
    convert_sample(16'sd0);
    convert_sample(16'sd32766);
    convert_sample(WORD_MAX);
  endtask

  task automatic test_read_past_end();
    wait_idle();
    load_config(16'sd0, WORD_MAX, 4'd7);
    convert_sample(16'sd32766);
    convert_sample(WORD_MAX);
    convert_sample(WORD_MIN);
    convert_sample(-16'sd1);
  endtask

  task automatic test_segment_wrap();
    wait_idle();
    load_config(WORD_MIN, WORD_MAX, 4'd1);
    convert_sample(-16'sd32256);
    convert_sample(WORD_MAX);
    convert_sample(WORD_MIN);
  endtask

  task automatic test_reversed_range();
    wait_idle();
    load_config(16'sd100, -16'sd100, 4'd1);
    convert_sample(16'sd50);
    convert_sample(16'sd200);
    convert_sample(WORD_MIN);
  endtask

  task automatic test_zero_step();
    wait_idle();
    load_config(16'sd0, 16'sd2, 4'd0);
    convert_sample(16'sd0);
    convert_sample(16'sd1);
    convert_sample(16'sd2);
    convert_sample(-16'sd1);
  endtask

  task automatic test_table_load();
    for (int i = 0; i < TABLE_DEPTH; i++) write_entry(8'(i), pick_word());
  endtask

  task automatic test_random_traffic(input int pct, input int first_cfg, input int n_cfgs);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic [3:0] sh;
    idle_pct = pct;
    for (int c = first_cfg; c < first_cfg + n_cfgs; c++) begin
      case (c)
        0: begin lo = WORD_MIN; hi = WORD_MAX; sh = 4'd15; end
        1: begin lo = WORD_MIN; hi = WORD_MAX; sh = 4'd8; end
        2: begin lo = WORD_MIN; hi = WORD_MAX; sh = 4'd1; end
        3: begin lo = 16'sd0; hi = WORD_MAX; sh = 4'd7; end
        4: begin lo = -16'sd1000; hi = 16'sd1000; sh = 4'd3; end
        5: begin lo = 16'sd1000; hi = -16'sd1000; sh = 4'd4; end
        6: begin lo = WORD_MIN; hi = WORD_MIN; sh = 4'd12; end
        7: begin lo = WORD_MAX; hi = WORD_MAX; sh = 4'd1; end
        default: begin
          lo = 16'($urandom);
          hi = 16'($urandom);
          sh = 4'($urandom_range(1, 15));
        end
      endcase
      wait_idle();
      load_config(lo, hi, sh);
      for (int n = 0; n < ITEMS_PER_CFG; n++) begin
        if ((c == 0 && n == ITEMS_PER_CFG / 2) || (pct != 0 && $urandom_range(99) == 0))
          wait_results();
        if ($urandom_range(99) < 15) write_entry(8'($urandom), pick_word());
        else convert_sample(pick_sample());
      end
    end
  endtask

  // every done beat is taken; compare with the oldest prediction
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst && done) begin
      if (pending_converted.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none actual %0d", $time, converted);
      end else begin
        want = pending_converted.pop_front();
        if (converted !== want) begin
          errors++;
          $display("%0t: converted mismatch: expected %0d actual %0d", $time, want, converted);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("uniform_step_interp_lut regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 12;
    test_table_edges();
    test_read_past_end();
    test_segment_wrap();
    test_reversed_range();
    test_zero_step();
    wait_idle();
    test_table_load();
    test_random_traffic(12, 0, 4);
    test_random_traffic(54, 4, 4);
    test_random_traffic(0, 8, 4);
    wait_idle();
    if (errors == 0) $display("uniform_step_interp_lut regression: pass");
    else $display("uniform_step_interp_lut regression: fail");
    $finish;
  end

endmodule
